// ----- hdl/frg_pkg.sv -----
// ----------------------------------------------------------------------------
// frg_pkg
// Shared types and constants for the flow rate gate table: item layouts,
// operation codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package frg_pkg;

    localparam int FLOW_IDX_W = 7;
    localparam int MODE_W     = 3;
    localparam int RATE_W     = 32;
    localparam int TIME_W     = 64;
    localparam int CLOCK_W    = 32;
    localparam int SCAN_CHUNK = 8;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd3000000000;

    localparam logic [MODE_W-1:0] MODE_REGISTER  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CHECK     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESUME    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TERMINATE = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [FLOW_IDX_W-1:0] flow_index;
        logic [RATE_W-1:0]     rate;
        logic [TIME_W-1:0]     now;
    } t_in_item;

    typedef struct packed {
        logic                  granted;
        logic [FLOW_IDX_W-1:0] slot;
        logic                  table_full;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;          // capture the input item, clear the result
        logic scan_clear;    // restart the free-slot scan
        logic scan_step;     // advance the scan by one chunk
        logic claim_take;    // hold the free slot found by the scan
        logic claim;         // mark the held slot active, store its rate
        logic rate_install;  // store a new rate, mark the slot limited
        logic do_pause;
        logic do_resume;
        logic do_term;
        logic set_grant;
        logic set_full;
        logic div_start;
        logic div_src;       // 0: rate of the item, 1: stored rate
        logic next_write;    // store now + period as the next allowed time
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic idx_ok;
        logic cur_active;
        logic cur_paused;
        logic cur_limited;
        logic rate_nz;
        logic scan_hit;
        logic scan_last;
        logic now_ge_next;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/frg_div.sv -----
// ----------------------------------------------------------------------------
// frg_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives a
// zero quotient.
// ----------------------------------------------------------------------------
module frg_div import frg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CLOCK_W-1:0] i_dividend,
    input  logic [RATE_W-1:0]  i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [CLOCK_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(CLOCK_W);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [CLOCK_W-1:0] r_quo;
    logic [RATE_W-1:0]  r_rem;
    logic [RATE_W-1:0]  r_dvs;
    logic               r_zero;

    logic [RATE_W:0]    w_sh;
    logic [RATE_W:0]    w_diff;
    logic               w_ge;

    assign w_sh   = {r_rem, r_quo[CLOCK_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = ~w_diff[RATE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(CLOCK_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[RATE_W-1:0] : w_sh[RATE_W-1:0];
            r_quo <= {r_quo[CLOCK_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 : r_quo;

endmodule

// ----- hdl/frg_dp.sv -----
// ----------------------------------------------------------------------------
// frg_dp
// Datapath: slot flags, rate and next-time memories, free-slot scanner,
// period divider, result staging and the output register.
// ----------------------------------------------------------------------------
module frg_dp import frg_pkg::*; #(
    parameter int FLOW_SLOTS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CLOCK_W-1:0] i_cfg_data,
    input  t_in_item           i_in,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_out_item          o_out,
    input  t_cmd               i_cmd,
    output t_sts               o_sts
);

    localparam int IDX_W  = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int NCHUNK = (FLOW_SLOTS + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W  = NCHUNK * SCAN_CHUNK;
    localparam int POS_W  = $clog2(SCAN_CHUNK);

    logic [CLOCK_W-1:0]    r_clock_hz;
    logic [MODE_W-1:0]     r_mode;
    logic [FLOW_IDX_W-1:0] r_idx;
    logic [RATE_W-1:0]     r_rate;
    logic [TIME_W-1:0]     r_now;
    logic [IDX_W-1:0]      r_wr_idx;
    logic [FLOW_SLOTS-1:0] r_active;
    logic [FLOW_SLOTS-1:0] r_paused;
    logic [FLOW_SLOTS-1:0] r_limited;
    logic [CH_W-1:0]       r_chunk;
    logic [RATE_W-1:0]     r_rd_rate;
    logic [TIME_W-1:0]     r_rd_next;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic [RATE_W-1:0] m_rate [FLOW_SLOTS];
    logic [TIME_W-1:0] m_next [FLOW_SLOTS];

    logic [PAD_W-1:0]      w_pad;
    logic [SCAN_CHUNK-1:0] w_chunk;
    logic [POS_W-1:0]      w_pos;
    logic                  w_rate_nz;
    logic [RATE_W-1:0]     w_divisor;
    logic [CLOCK_W-1:0]    w_quo;
    logic                  w_div_busy;
    logic                  w_div_done;

    assign w_rate_nz = (r_rate != '0);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_RESET;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in.mode;
            r_idx  <= i_in.flow_index;
            r_rate <= i_in.rate;
            r_now  <= i_in.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wr_idx <= IDX_W'(i_in.flow_index);
        end else if (i_cmd.claim_take) begin
            r_wr_idx <= IDX_W'({r_chunk, w_pos});
        end
    end

    // Slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_paused  <= '0;
            r_limited <= '0;
        end else begin
            if (i_cmd.claim) begin
                r_active[r_wr_idx]  <= 1'b1;
                r_limited[r_wr_idx] <= w_rate_nz;
            end
            if (i_cmd.rate_install) begin
                r_limited[r_wr_idx] <= 1'b1;
            end
            if (i_cmd.do_pause) begin
                r_paused[r_wr_idx] <= 1'b1;
            end
            if (i_cmd.do_resume) begin
                r_paused[r_wr_idx] <= 1'b0;
            end
            if (i_cmd.do_term) begin
                r_active[r_wr_idx] <= 1'b0;
                r_paused[r_wr_idx] <= 1'b0;
            end
        end
    end

    // Free-slot scan, one chunk of slots per cycle; padding reads as in use
    for (genvar g = 0; g < PAD_W; g++) begin : g_pad
        if (g < FLOW_SLOTS) begin : g_slot
            assign w_pad[g] = r_active[g];
        end else begin : g_fill
            assign w_pad[g] = 1'b1;
        end
    end

    assign w_chunk = w_pad[r_chunk * SCAN_CHUNK +: SCAN_CHUNK];

    always_comb begin
        w_pos = '0;
        for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
            if (!w_chunk[i]) begin
                w_pos = POS_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_cmd.scan_clear) begin
            r_chunk <= '0;
        end else if (i_cmd.scan_step) begin
            r_chunk <= r_chunk + 1'b1;
        end
    end

    // Rate and next-time memories, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim || i_cmd.rate_install) begin
            m_rate[r_wr_idx] <= r_rate;
        end
        r_rd_rate <= m_rate[r_wr_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.next_write) begin
            m_next[r_wr_idx] <= r_now + TIME_W'(w_quo);
        end
        r_rd_next <= m_next[r_wr_idx];
    end

    // Period divider
    assign w_divisor = i_cmd.div_src ? r_rd_rate : r_rate;

    frg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_clock_hz),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // Result staging and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res <= '0;
        end else begin
            if (i_cmd.set_grant) begin
                r_res.granted <= 1'b1;
            end
            if (i_cmd.set_full) begin
                r_res.table_full <= 1'b1;
            end
            if (i_cmd.claim) begin
                r_res.slot <= FLOW_IDX_W'(r_wr_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        o_sts             = '0;
        o_sts.mode        = r_mode;
        o_sts.idx_ok      = (32'(r_idx) < 32'(FLOW_SLOTS));
        o_sts.cur_active  = r_active[r_wr_idx];
        o_sts.cur_paused  = r_paused[r_wr_idx];
        o_sts.cur_limited = r_limited[r_wr_idx];
        o_sts.rate_nz     = w_rate_nz;
        o_sts.scan_hit    = ~(&w_chunk);
        o_sts.scan_last   = (r_chunk == CH_W'(NCHUNK - 1));
        o_sts.now_ge_next = (r_now >= r_rd_next);
        o_sts.div_busy    = w_div_busy;
        o_sts.div_done    = w_div_done;
        o_sts.out_free    = ~r_out_valid | i_out_ready;
    end

`ifndef SYNTHESIS
    a_claim_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |-> !r_active[r_wr_idx])
        else $error("claimed slot was already active");

    a_next_limited : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.next_write |-> r_limited[r_wr_idx])
        else $error("next time written for a slot that is not limited");

    a_grant_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_grant |-> (r_mode == MODE_CHECK))
        else $error("grant raised outside a check");
`endif

endmodule

// ----- hdl/frg_ctrl.sv -----
// ----------------------------------------------------------------------------
// frg_ctrl
// Controller: sequences one operation at a time through decode, scan,
// memory compare, period division and result delivery.
// ----------------------------------------------------------------------------
module frg_ctrl import frg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CLAIM,
        S_CMP,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_sts.mode)
                    MODE_REGISTER: begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = S_SCAN;
                    end
                    MODE_CHECK: begin
                        if (i_sts.idx_ok && i_sts.cur_active && !i_sts.cur_paused) begin
                            if (!i_sts.cur_limited) begin
                                o_cmd.set_grant = 1'b1;
                            end else begin
                                n_state = S_CMP;
                            end
                        end
                    end
                    MODE_PAUSE: begin
                        o_cmd.do_pause = i_sts.idx_ok;
                    end
                    MODE_RESUME: begin
                        if (i_sts.idx_ok) begin
                            o_cmd.do_resume = 1'b1;
                            if (i_sts.rate_nz) begin
                                o_cmd.rate_install = 1'b1;
                                o_cmd.div_start    = 1'b1;
                                n_state            = S_DIV;
                            end
                        end
                    end
                    MODE_TERMINATE: begin
                        o_cmd.do_term = i_sts.idx_ok;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    o_cmd.claim_take = 1'b1;
                    n_state          = S_CLAIM;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_CLAIM: begin
                o_cmd.claim = 1'b1;
                if (i_sts.rate_nz) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (i_sts.now_ge_next) begin
                    o_cmd.set_grant = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.next_write = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");

    a_out_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register overwritten before transfer");

    a_load_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("item taken while an operation is in flight");
`endif

endmodule

// ----- hdl/flow_rate_gate_table.sv -----
// ----------------------------------------------------------------------------
// flow_rate_gate_table
// Table of flow slots with a per-flow rate gate: register, check, pause,
// resume and terminate, one result per operation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ----------------------------
//  in       to block   i_in_valid / o_in_ready    t_in_item  (mode .. now)
//  out      from block o_out_valid / i_out_ready  t_out_item (granted .. full)
//  cfg      to block   i_cfg_valid / o_cfg_ready  clock_rate_hz, 32 bits
//
//  Operations: one at a time. A period (clock_rate_hz / rate) is computed in
//  the shared bit-serial divider for a register or a resume with a rate and
//  for a limited check that grants. Register scans 8 slots per cycle.
//  Reset: synchronous, active low; clears slot flags, the controller and
//  the output register, and loads clock_rate_hz with 3000000000.
//  Stalls: the next item is taken while a result waits in the output
//  register; a result that cannot move holds the controller in its last
//  state. The configuration port is always ready.
//
module flow_rate_gate_table import frg_pkg::*; #(
    parameter int FLOW_SLOTS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operation items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    // timebase configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CLOCK_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration lands in the timebase register at the transfer; always accept the transfer.
    assign o_cfg_ready = 1'b1;

    // Sequencer: walks each operation through its steps.
    frg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Slot state, memories, scanner, divider and output register.
    frg_dp #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flow rate gate table. An initial block queues
// operations phase by phase; a clocked driver moves them over the input
// channel, predicts each result at its transfer, and a clocked monitor
// compares every result transfer against the oldest prediction. The timebase
// register is rewritten between phases while the table is idle.
// ----------------------------------------------------------------------------
module tb;
    import frg_pkg::*;

    localparam int SLOTS = 128;
    // First of the three undefined operation codes; the table ignores them
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd5;
    localparam int SETTLE_CYCLES = 60;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_item   = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CLOCK_W-1:0] cfg_data  = '0;
    logic               in_ready;
    logic               out_valid;
    logic               cfg_ready;
    t_out_item          out_item;

    flow_rate_gate_table #(
        .FLOW_SLOTS (SLOTS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Predicted table contents and timebase
    logic [CLOCK_W-1:0] gate_clock = CLOCK_RESET;
    logic               flow_on     [SLOTS];
    logic               flow_held   [SLOTS];
    logic               flow_capped [SLOTS];
    logic [RATE_W-1:0]  flow_rate   [SLOTS];
    logic [TIME_W-1:0]  flow_next   [SLOTS];

    // Stimulus bookkeeping: which slots the queued operations leave active
    logic               gen_on [SLOTS];
    int                 gen_live  = 0;
    logic [CLOCK_W-1:0] gen_clock = CLOCK_RESET;
    logic [TIME_W-1:0]  gen_time  = '0;

    t_in_item           ops_pending[$];
    t_out_item          verdicts_due[$];
    logic [CLOCK_W-1:0] clock_writes[$];

    int   ops_issued    = 0;
    int   results_seen  = 0;
    int   clocks_issued = 0;
    int   clocks_taken  = 0;
    int   mismatches    = 0;
    int   gap_left      = 0;
    int   stall_left    = 0;
    logic calm          = 1'b0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            flow_on[i]     = 1'b0;
            flow_held[i]   = 1'b0;
            flow_capped[i] = 1'b0;
            flow_rate[i]   = '0;
            flow_next[i]   = '0;
            gen_on[i]      = 1'b0;
        end
    end

    initial begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Ticks between grants for a rate; an unset rate or timebase gives none
    function automatic logic [TIME_W-1:0] tick_period(logic [RATE_W-1:0] r);
        if (r == '0 || gate_clock == '0)
            return '0;
        return TIME_W'(gate_clock) / TIME_W'(r);
    endfunction

    // Apply one operation to the predicted table and return its result
    function automatic t_out_item gate_step(t_in_item op);
        t_out_item res;
        int        k;
        int        hit;
        res = '0;
        k   = int'(op.flow_index);
        hit = -1;
        if (op.mode == MODE_REGISTER) begin
            // claim the lowest free slot
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!flow_on[i])
                    hit = i;
            if (hit < 0) begin
                res.table_full = 1'b1;
            end else begin
                flow_on[hit]     = 1'b1;
                flow_capped[hit] = (op.rate != '0);
                flow_rate[hit]   = op.rate;
                if (op.rate != '0)
                    flow_next[hit] = op.now + tick_period(op.rate);
                res.slot = FLOW_IDX_W'(hit);
            end
        end else if (k < SLOTS) begin
            case (op.mode)
                MODE_CHECK: begin
                    if (flow_on[k] && !flow_held[k]) begin
                        if (!flow_capped[k]) begin
                            res.granted = 1'b1;
                        end else if (op.now >= flow_next[k]) begin
                            // re-arm from now, not from the old deadline
                            flow_next[k] = op.now + tick_period(flow_rate[k]);
                            res.granted  = 1'b1;
                        end
                    end
                end
                MODE_PAUSE: begin
                    flow_held[k] = 1'b1;
                end
                MODE_RESUME: begin
                    flow_held[k] = 1'b0;
                    if (op.rate != '0) begin
                        flow_rate[k]   = op.rate;
                        flow_capped[k] = 1'b1;
                        flow_next[k]   = op.now + tick_period(op.rate);
                    end
                end
                MODE_TERMINATE: begin
                    flow_on[k]   = 1'b0;
                    flow_held[k] = 1'b0;
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Driver: move queued operations over the input channel, with idle bursts
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            // Predict on the transfer, in the order the table sees operations
            if (in_valid && in_ready)
                verdicts_due.push_back(gate_step(in_item));
            // Hold the payload until it transfers
            if (!in_valid || in_ready) begin
                if (gap_left > 0 && !calm) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (ops_pending.size() > 0) begin
                    in_item  <= ops_pending.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 11);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Timebase writes; update the predicted timebase on the transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                gate_clock = cfg_data;
                clocks_taken++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (clock_writes.size() > 0) begin
                    cfg_data  <= clock_writes.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer, stall the output in bursts
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (verdicts_due.size() == 0) begin
                    flag_mismatch("result with nothing pending", 64'(out_item), 64'd0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (out_item.granted !== want.granted)
                        flag_mismatch("granted", 64'(out_item.granted),
                                      64'(want.granted));
                    if (out_item.slot !== want.slot)
                        flag_mismatch("slot", 64'(out_item.slot), 64'(want.slot));
                    if (out_item.table_full !== want.table_full)
                        flag_mismatch("table_full", 64'(out_item.table_full),
                                      64'(want.table_full));
                end
            end
            if (stall_left > 0 && !calm) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Queue one operation and track which slots it leaves active
    task automatic push_op(logic [MODE_W-1:0] m, int idx, logic [RATE_W-1:0] r,
                           logic [TIME_W-1:0] t);
        t_in_item op;
        int       hit;
        op.mode       = m;
        op.flow_index = FLOW_IDX_W'(idx);
        op.rate       = r;
        op.now        = t;
        hit           = -1;
        if (m == MODE_REGISTER) begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!gen_on[i])
                    hit = i;
            if (hit >= 0) begin
                gen_on[hit] = 1'b1;
                gen_live++;
            end
        end else if (m == MODE_TERMINATE && gen_on[op.flow_index]) begin
            gen_on[op.flow_index] = 1'b0;
            gen_live--;
        end
        ops_pending.push_back(op);
        ops_issued++;
    endtask

    // Mostly unlimited or periods of a few thousand ticks, some raw rates
    function automatic logic [RATE_W-1:0] pick_rate();
        logic [RATE_W-1:0] r;
        case ($urandom_range(0, 9))
            0, 1, 2: r = '0;
            3:       r = $urandom;
            default: begin
                r = gen_clock / $urandom_range(1, 5000);
                if (r == '0)
                    r = 1;
            end
        endcase
        return r;
    endfunction

    // Advance the timeline; now and then jump near the wrap or throw noise
    function automatic logic [TIME_W-1:0] pick_now();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return {$urandom, $urandom};
        if (roll < 5)
            gen_time = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 20000);
        else
            gen_time = gen_time + $urandom_range(0, 3000);
        return gen_time;
    endfunction

    // An active slot when there is one, else any slot
    function automatic int pick_flow();
        int live[$];
        foreach (gen_on[i])
            if (gen_on[i])
                live.push_back(i);
        if (live.size() == 0)
            return $urandom_range(0, SLOTS - 1);
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic push_random_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            push_op(MODE_CHECK, pick_flow(), $urandom, pick_now());
        else if (roll < 50)
            push_op(MODE_REGISTER, $urandom_range(0, SLOTS - 1), pick_rate(), pick_now());
        else if (roll < 58)
            push_op(MODE_PAUSE, pick_flow(), $urandom, pick_now());
        else if (roll < 72)
            push_op(MODE_RESUME, pick_flow(), pick_rate(), pick_now());
        else if (roll < 80)
            push_op(MODE_TERMINATE, pick_flow(), $urandom, pick_now());
        else if (roll < 90)
            push_op(MODE_CHECK + MODE_W'($urandom_range(0, 3)),
                    $urandom_range(0, SLOTS - 1), $urandom, {$urandom, $urandom});
        else if (roll < 95)
            push_op(MODE_SPARE + MODE_W'($urandom_range(0, 2)),
                    $urandom_range(0, SLOTS - 1), $urandom, {$urandom, $urandom});
        else
            push_op(MODE_CHECK, pick_flow(), $urandom, gen_time);
    endtask

    // Wait until every queued operation has returned its result
    task automatic await_idle();
        while (results_seen < ops_issued)
            @(posedge clk);
    endtask

    task automatic set_clock(logic [CLOCK_W-1:0] v);
        await_idle();
        clock_writes.push_back(v);
        gen_clock = v;
        clocks_issued++;
        while (clocks_taken < clocks_issued)
            @(posedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at the reset timebase (3e9 ticks per second)
        push_op(MODE_REGISTER, 0, 0, 0);                       // unlimited, slot 0
        push_op(MODE_CHECK, 0, 0, 0);
        push_op(MODE_REGISTER, 0, 1000000, 100);               // slot 1, next 3100
        push_op(MODE_CHECK, 1, 0, 3099);                       // one tick early
        push_op(MODE_CHECK, 1, 0, 3100);                       // exactly on time
        push_op(MODE_CHECK, 1, 0, 3100);                       // re-armed, refused
        push_op(MODE_PAUSE, 1, 0, 0);
        push_op(MODE_CHECK, 1, 0, 10000);                      // paused, refused
        push_op(MODE_RESUME, 1, 0, 10000);                     // keep the old rate
        push_op(MODE_CHECK, 1, 0, 10000);
        push_op(MODE_RESUME, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // zero period
        push_op(MODE_CHECK, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_op(MODE_REGISTER, 127, 1, 64'hFFFF_FFFF_FFFF_FFF0); // deadline wraps
        push_op(MODE_CHECK, 2, 0, 5);
        push_op(MODE_CHECK, 2, 0, 64'd3000000000);
        push_op(MODE_TERMINATE, 0, 0, 0);
        push_op(MODE_CHECK, 0, 0, 0);                          // free slot
        push_op(MODE_PAUSE, 0, 0, 0);                          // pause a free slot
        push_op(MODE_REGISTER, 0, 0, 0);                       // reclaims slot 0, still paused
        push_op(MODE_CHECK, 0, 0, 0);
        push_op(MODE_TERMINATE, 127, 0, 0);
        push_op(MODE_RESUME, 127, 7, 0);                       // rate on a free slot
        push_op(MODE_CHECK, 127, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_op(MODE_SPARE, 127, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_op(MODE_SPARE + 3'd1, 0, 0, 0);
        push_op(MODE_SPARE + 3'd2, 85, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);

        // Slowest timebase: every nonzero rate gives a period of at most one tick
        set_clock(32'd1);
        repeat (100) push_random_op();

        // Fastest timebase; fill the table, overflow it, then free and reuse slots
        set_clock(32'hFFFF_FFFF);
        while (gen_live < SLOTS) begin
            push_op(MODE_REGISTER, $urandom_range(0, SLOTS - 1), pick_rate(), pick_now());
            if ($urandom_range(0, 1) == 0)
                push_op(MODE_CHECK, pick_flow(), $urandom, pick_now());
        end
        repeat (3) push_op(MODE_REGISTER, $urandom_range(0, SLOTS - 1), pick_rate(), pick_now());
        repeat (4) push_op(MODE_TERMINATE, pick_flow(), $urandom, pick_now());
        repeat (5) push_op(MODE_REGISTER, $urandom_range(0, SLOTS - 1), pick_rate(), pick_now());
        repeat (40) push_random_op();

        set_clock($urandom_range(1000, 32'hFFFF_FFFF));
        repeat (70) push_random_op();

        // Final stretch at the reset timebase without idle bursts
        set_clock(CLOCK_RESET);
        calm = 1'b1;
        repeat (50) push_random_op();

        await_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (verdicts_due.size() > 0)
            flag_mismatch("missing result", 64'd0, 64'(verdicts_due.pop_front()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
